// ===== src/ptsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsp_pkg
// Shared types and constants of the point-in-triangle-strip test: register
// map, controller states, triangle select codes and the command bundle.
// ----------------------------------------------------------------------------
package ptsp_pkg;

    localparam int IDX_BITS   = 8;
    localparam int CNT_BITS   = 9;
    localparam int TOL_BITS   = 20;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [CNT_BITS-1:0] POINT_COUNT_RESET = 9'd3;
    localparam logic [TOL_BITS-1:0] TOLERANCE_RESET   = 20'd1311;

    typedef enum logic [0:0] {
        CFG_POINT_COUNT = 1'b0,
        CFG_TOLERANCE   = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_TRI_A,
        ST_TRI_B,
        ST_CLOSE_C,
        ST_CLOSE_D,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        TRI_NONE,
        TRI_LEAD,
        TRI_TRAIL,
        TRI_WRAP_IN,
        TRI_WRAP_OUT
    } tri_sel_t;

    typedef struct packed {
        logic     start;
        logic     take_first;
        logic     advance;
        tri_sel_t tri_sel;
        logic     load_out;
    } ctrl_cmd_t;

endpackage

// ===== src/point_in_triangle_strip_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_strip_test_top
// Point-in-closed-strip test: stores inner and outer boundary pairs and tests
// query points against every triangle of the strip by area sums.
// ----------------------------------------------------------------------------
// A load beat (mode 0) writes one inner/outer pair and yields no result. A query
// beat (mode 1) reads the stored pairs one at a time from the two point RAMs
// and pushes one triangle per cycle into a six-stage area-sum pipeline; the
// query time grows with the number of pairs in use and is set by that single
// triangle pipeline and the one read port of each point RAM. No new beat is
// accepted until the result beat is loaded. Slots not yet loaded hold no
// defined value; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module point_in_triangle_strip_test_top #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 20
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ptsp_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [ptsp_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [ptsp_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic [ptsp_pkg::IDX_BITS-1:0]         s_point_index,
    input  logic signed [COORD_BITS-1:0]          s_point_x,
    input  logic signed [COORD_BITS-1:0]          s_point_z,
    input  logic signed [COORD_BITS-1:0]          s_outer_x,
    input  logic signed [COORD_BITS-1:0]          s_outer_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_on_strip
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int PW = 2 * COORD_BITS;

    logic [ptsp_pkg::CNT_BITS-1:0] point_count_reg;
    logic [ptsp_pkg::TOL_BITS-1:0] tolerance_reg;
    ptsp_pkg::cfg_reg_t            cfg_idx;
    logic                          cfg_wr;

    ptsp_pkg::ctrl_cmd_t cmd;
    logic                pipe_busy;
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [PW-1:0]       rd_inner;
    logic [PW-1:0]       rd_outer;

    assign pready  = 1'b1;
    assign cfg_idx = ptsp_pkg::cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= ptsp_pkg::POINT_COUNT_RESET;
            tolerance_reg   <= ptsp_pkg::TOLERANCE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ptsp_pkg::CFG_POINT_COUNT: point_count_reg <= pwdata[ptsp_pkg::CNT_BITS-1:0];
                ptsp_pkg::CFG_TOLERANCE:   tolerance_reg   <= pwdata[ptsp_pkg::TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ptsp_pkg::CFG_POINT_COUNT: prdata = ptsp_pkg::PDATA_BITS'(point_count_reg);
            ptsp_pkg::CFG_TOLERANCE:   prdata = ptsp_pkg::PDATA_BITS'(tolerance_reg);
            default:                   prdata = '0;
        endcase
    end

    assign wr_addr = AW'(s_point_index);

    ptsp_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_point_index (s_point_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .point_count   (point_count_reg),
        .pipe_busy     (pipe_busy),
        .cmd           (cmd),
        .wr_en         (wr_en),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr)
    );

    ptsp_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_inner_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({s_point_x, s_point_z}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_inner)
    );

    ptsp_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_outer_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({s_outer_x, s_outer_z}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_outer)
    );

    ptsp_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_point_x  (s_point_x),
        .s_point_z  (s_point_z),
        .rd_inner   (rd_inner),
        .rd_outer   (rd_outer),
        .tolerance  (tolerance_reg),
        .pipe_busy  (pipe_busy),
        .m_on_strip (m_on_strip)
    );

endmodule

// ===== src/ptsp_ram.sv =====
// ----------------------------------------------------------------------------
// ptsp_ram
// Generic single-write, single-read RAM with registered read data. Read data
// holds until the next read.
// ----------------------------------------------------------------------------
module ptsp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ptsp_dpath.sv =====
// ----------------------------------------------------------------------------
// ptsp_dpath
// Triangle datapath: holds the query point and the current and first boundary
// pairs, selects the triangle vertices and runs one triangle per cycle through
// a six-stage area-sum pipeline, collecting the hit flag.
// ----------------------------------------------------------------------------
module ptsp_dpath #(
    parameter int COORD_BITS = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ptsp_pkg::ctrl_cmd_t                 cmd,
    input  logic signed [COORD_BITS-1:0]        s_point_x,
    input  logic signed [COORD_BITS-1:0]        s_point_z,
    input  logic [2*COORD_BITS-1:0]             rd_inner,
    input  logic [2*COORD_BITS-1:0]             rd_outer,
    input  logic [ptsp_pkg::TOL_BITS-1:0]       tolerance,
    output logic                                pipe_busy,
    output logic                                m_on_strip
);

    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C;
    localparam int DW = C + 1;
    localparam int MW = 2 * DW;
    localparam int SW = (2 * C + 4 > ptsp_pkg::TOL_BITS + 2) ? 2 * C + 4
                                                             : ptsp_pkg::TOL_BITS + 2;

    logic [PW-1:0] query_reg;
    logic [PW-1:0] cur_in_reg;
    logic [PW-1:0] cur_out_reg;
    logic [PW-1:0] first_in_reg;
    logic [PW-1:0] first_out_reg;

    logic [PW-1:0] va;
    logic [PW-1:0] vb;
    logic [PW-1:0] vc;
    logic signed [C-1:0] ax, az, bx, bz, cx, cz, qx, qz;

    logic signed [DW-1:0] d1x_reg, d1z_reg, e1x_reg, e1z_reg, d2x_reg, d2z_reg;
    logic signed [DW-1:0] d3x_reg, d3z_reg, e3x_reg, e3z_reg;
    logic signed [MW-1:0] pa_reg [4];
    logic signed [MW-1:0] pb_reg [4];
    logic signed [MW-1:0] det_reg [4];
    logic [MW-1:0]        mag_reg [4];
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] base_reg;
    logic signed [SW-1:0] diff_reg;
    logic signed [SW-1:0] tol_s;

    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic       issue;
    logic       hit_reg;
    logic       on_strip_reg;
    logic       tri_hit;

    // Vertex selection
    always_comb begin
        unique case (cmd.tri_sel)
            ptsp_pkg::TRI_LEAD: begin
                va = cur_in_reg;
                vb = cur_out_reg;
                vc = rd_inner;
            end
            ptsp_pkg::TRI_TRAIL: begin
                va = rd_inner;
                vb = rd_outer;
                vc = cur_out_reg;
            end
            ptsp_pkg::TRI_WRAP_IN: begin
                va = cur_in_reg;
                vb = first_in_reg;
                vc = cur_out_reg;
            end
            ptsp_pkg::TRI_WRAP_OUT: begin
                va = first_in_reg;
                vb = first_out_reg;
                vc = cur_out_reg;
            end
            default: begin
                va = cur_in_reg;
                vb = cur_out_reg;
                vc = first_in_reg;
            end
        endcase
        ax = $signed(va[PW-1:C]);
        az = $signed(va[C-1:0]);
        bx = $signed(vb[PW-1:C]);
        bz = $signed(vb[C-1:0]);
        cx = $signed(vc[PW-1:C]);
        cz = $signed(vc[C-1:0]);
        qx = $signed(query_reg[PW-1:C]);
        qz = $signed(query_reg[C-1:0]);
    end

    assign issue = (cmd.tri_sel != ptsp_pkg::TRI_NONE);
    assign tol_s = $signed(SW'(tolerance));
    assign tri_hit = (diff_reg <= tol_s) && (diff_reg >= -tol_s);
    assign pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            if (cmd.start) begin
                hit_reg <= 1'b0;
            end else if (v6_reg && tri_hit) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            query_reg <= {s_point_x, s_point_z};
        end
        if (cmd.take_first) begin
            first_in_reg  <= rd_inner;
            first_out_reg <= rd_outer;
            cur_in_reg    <= rd_inner;
            cur_out_reg   <= rd_outer;
        end else if (cmd.advance) begin
            cur_in_reg  <= rd_inner;
            cur_out_reg <= rd_outer;
        end
        if (cmd.load_out) begin
            on_strip_reg <= hit_reg;
        end

        // stage 1: edge vectors
        d1x_reg <= DW'(bx) - DW'(ax);
        d1z_reg <= DW'(bz) - DW'(az);
        e1x_reg <= DW'(qx) - DW'(ax);
        e1z_reg <= DW'(qz) - DW'(az);
        d2x_reg <= DW'(cx) - DW'(ax);
        d2z_reg <= DW'(cz) - DW'(az);
        d3x_reg <= DW'(cx) - DW'(bx);
        d3z_reg <= DW'(cz) - DW'(bz);
        e3x_reg <= DW'(qx) - DW'(bx);
        e3z_reg <= DW'(qz) - DW'(bz);

        // stage 2: cross-product terms
        pa_reg[0] <= MW'(d1x_reg) * MW'(e1z_reg);
        pb_reg[0] <= MW'(d1z_reg) * MW'(e1x_reg);
        pa_reg[1] <= MW'(d2x_reg) * MW'(e1z_reg);
        pb_reg[1] <= MW'(d2z_reg) * MW'(e1x_reg);
        pa_reg[2] <= MW'(d3x_reg) * MW'(e3z_reg);
        pb_reg[2] <= MW'(d3z_reg) * MW'(e3x_reg);
        pa_reg[3] <= MW'(d1x_reg) * MW'(d2z_reg);
        pb_reg[3] <= MW'(d1z_reg) * MW'(d2x_reg);

        // stages 3 and 4: determinant, magnitude
        for (int k = 0; k < 4; k++) begin
            det_reg[k] <= pa_reg[k] - pb_reg[k];
            mag_reg[k] <= det_reg[k][MW-1] ? $unsigned(-det_reg[k]) : $unsigned(det_reg[k]);
        end

        // stages 5 and 6: area sum, mismatch
        sum_reg  <= $signed(SW'(mag_reg[0])) + $signed(SW'(mag_reg[1]))
                  + $signed(SW'(mag_reg[2]));
        base_reg <= $signed(SW'(mag_reg[3]));
        diff_reg <= sum_reg - base_reg;
    end

    assign m_on_strip = on_strip_reg;

endmodule

// ===== src/ptsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptsp_ctrl
// Sequencer of the strip test: accepts load and query beats, walks the stored
// pairs one read a pair, issues two triangles for each pair after the first plus
// the two closing triangles, waits for the pipeline to drain and holds the result beat.
// ----------------------------------------------------------------------------
module ptsp_ctrl #(
    parameter int MAX_POINTS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [ptsp_pkg::IDX_BITS-1:0]       s_point_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    input  logic [ptsp_pkg::CNT_BITS-1:0]       point_count,
    input  logic                                pipe_busy,
    output ptsp_pkg::ctrl_cmd_t                 cmd,
    output logic                                wr_en,
    output logic                                rd_en,
    output logic [$clog2(MAX_POINTS)-1:0]       rd_addr
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = (ptsp_pkg::CNT_BITS > AW + 1) ? ptsp_pkg::CNT_BITS : AW + 1;

    ptsp_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    k_reg, k_next;
    logic             m_valid_reg, m_valid_next;
    logic [CNTW-1:0]  count_w;
    logic [CNTW-1:0]  count_eff;
    logic [AW-1:0]    last;
    logic             idx_ok;

    always_comb begin
        count_w = CNTW'(point_count);
        if (count_w > CNTW'(MAX_POINTS)) begin
            count_eff = CNTW'(MAX_POINTS);
        end else if (count_w == '0) begin
            count_eff = CNTW'(1);
        end else begin
            count_eff = count_w;
        end
    end

    assign last   = AW'(count_eff - CNTW'(1));
    assign idx_ok = 32'(s_point_index) < MAX_POINTS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptsp_pkg::ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = k_reg + AW'(1);
        cmd.start      = 1'b0;
        cmd.take_first = 1'b0;
        cmd.advance    = 1'b0;
        cmd.tri_sel    = ptsp_pkg::TRI_NONE;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            ptsp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = '0;
                if (s_valid) begin
                    if (s_mode) begin
                        cmd.start  = 1'b1;
                        rd_en      = 1'b1;
                        k_next     = '0;
                        state_next = ptsp_pkg::ST_FIRST;
                    end else begin
                        wr_en = idx_ok;
                    end
                end
            end
            ptsp_pkg::ST_FIRST: begin
                cmd.take_first = 1'b1;
                if (last == '0) begin
                    state_next = ptsp_pkg::ST_CLOSE_C;
                end else begin
                    rd_en      = 1'b1;
                    k_next     = k_reg + AW'(1);
                    state_next = ptsp_pkg::ST_TRI_A;
                end
            end
            ptsp_pkg::ST_TRI_A: begin
                cmd.tri_sel = ptsp_pkg::TRI_LEAD;
                state_next  = ptsp_pkg::ST_TRI_B;
            end
            ptsp_pkg::ST_TRI_B: begin
                cmd.tri_sel = ptsp_pkg::TRI_TRAIL;
                cmd.advance = 1'b1;
                if (k_reg == last) begin
                    state_next = ptsp_pkg::ST_CLOSE_C;
                end else begin
                    rd_en      = 1'b1;
                    k_next     = k_reg + AW'(1);
                    state_next = ptsp_pkg::ST_TRI_A;
                end
            end
            ptsp_pkg::ST_CLOSE_C: begin
                cmd.tri_sel = ptsp_pkg::TRI_WRAP_IN;
                state_next  = ptsp_pkg::ST_CLOSE_D;
            end
            ptsp_pkg::ST_CLOSE_D: begin
                cmd.tri_sel = ptsp_pkg::TRI_WRAP_OUT;
                state_next  = ptsp_pkg::ST_DRAIN;
            end
            ptsp_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = ptsp_pkg::ST_RESULT;
                end
            end
            ptsp_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ptsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptsp_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_result_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptsp_pkg::ST_RESULT) |-> !pipe_busy)
        else $error("result taken with triangles in flight");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && state_reg != ptsp_pkg::ST_IDLE) |-> (k_reg < last))
        else $error("pair read beyond last slot in use");

    a_valid_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ptsp_pkg::ST_RESULT))
        else $error("result beat raised outside result state");

    a_wrap_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tri_sel == ptsp_pkg::TRI_WRAP_IN) |=> (cmd.tri_sel == ptsp_pkg::TRI_WRAP_OUT))
        else $error("closing triangles not issued as a pair");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for point_in_triangle_strip_test_top. A directed table
// of loads, queries and register writes runs first, then randomised phases,
// each setting a pair count, a tolerance and an idling pattern. Every result
// beat is checked against a directed answer or an in-bench area-sum model of the strip.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   MAX_PAIRS   = 256;
    localparam int   CW          = 20;
    localparam int   QUIET_LIMIT = 20000;
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct {
        longint x;
        longint z;
    } pt_t;

    typedef struct {
        logic                            mode;
        logic [ptsp_pkg::IDX_BITS-1:0]   index;
        logic signed [CW-1:0]            px;
        logic signed [CW-1:0]            pz;
        logic signed [CW-1:0]            ox;
        logic signed [CW-1:0]            oz;
    } beat_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;
    typedef enum logic [1:0] {BY_MODEL, SAYS_OUT, SAYS_IN} row_answer_t;

    typedef struct {
        row_kind_t              kind;
        ptsp_pkg::cfg_reg_t     sel;
        logic [31:0]            value;
        beat_t                  b;
        row_answer_t            answer;
    } row_t;

    logic                                aclk          = 1'b0;
    logic                                aresetn       = 1'b0;
    logic                                psel          = 1'b0;
    logic                                penable       = 1'b0;
    logic                                pwrite        = 1'b0;
    logic [ptsp_pkg::PADDR_BITS-1:0]     paddr         = '0;
    logic [ptsp_pkg::PDATA_BITS-1:0]     pwdata        = '0;
    logic [ptsp_pkg::PDATA_BITS-1:0]     prdata;
    logic                                pready;
    logic                                s_valid       = 1'b0;
    logic                                s_ready;
    logic                                s_mode        = 1'b0;
    logic [ptsp_pkg::IDX_BITS-1:0]       s_point_index = '0;
    logic signed [CW-1:0]                s_point_x     = '0;
    logic signed [CW-1:0]                s_point_z     = '0;
    logic signed [CW-1:0]                s_outer_x     = '0;
    logic signed [CW-1:0]                s_outer_z     = '0;
    logic                                m_valid;
    logic                                m_ready       = 1'b0;
    logic                                m_on_strip;

    point_in_triangle_strip_test_top #(
        .MAX_POINTS (MAX_PAIRS),
        .COORD_BITS (CW)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_point_index (s_point_index),
        .s_point_x     (s_point_x),
        .s_point_z     (s_point_z),
        .s_outer_x     (s_outer_x),
        .s_outer_z     (s_outer_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_on_strip    (m_on_strip)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    pt_t                            inner_pts [MAX_PAIRS];
    pt_t                            outer_pts [MAX_PAIRS];
    logic [ptsp_pkg::CNT_BITS-1:0]  count_shadow = ptsp_pkg::POINT_COUNT_RESET;
    logic [ptsp_pkg::TOL_BITS-1:0]  tol_shadow   = ptsp_pkg::TOLERANCE_RESET;
    logic                           pending_hits [$];
    int                             result_seq   = 0;
    int                             error_count  = 0;
    int                             snd_idle_pct = 30;
    int                             rcv_idle_pct = 83;
    int                             quiet_cycles = 0;
    int                             strip_x0;
    int                             strip_step;
    int                             strip_zc;
    int                             strip_w;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic signed [CW-1:0] crd(input int v);
        return v[CW-1:0];
    endfunction

    function automatic int active_pairs();
        int n;
        n = count_shadow;
        if (n > MAX_PAIRS) n = MAX_PAIRS;
        if (n == 0) n = 1;
        return n;
    endfunction

    function automatic longint twice_area(input pt_t a, input pt_t b, input pt_t c);
        longint d;
        d = (b.x - a.x) * (c.z - a.z) - (b.z - a.z) * (c.x - a.x);
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic in_triangle(input pt_t p, input pt_t a, input pt_t b,
                                         input pt_t c);
        longint d;
        d = twice_area(a, b, p) + twice_area(a, c, p) + twice_area(b, c, p)
            - twice_area(a, b, c);
        if (d < 0) d = -d;
        return d <= longint'(tol_shadow);
    endfunction

    function automatic logic strip_hit(input pt_t p);
        int last;
        last = active_pairs() - 1;
        for (int i = 0; i < last; i++) begin
            if (in_triangle(p, inner_pts[i], outer_pts[i], inner_pts[i+1]) ||
                in_triangle(p, inner_pts[i+1], outer_pts[i+1], outer_pts[i]))
                return 1'b1;
        end
        return in_triangle(p, inner_pts[last], inner_pts[0], outer_pts[last]) ||
               in_triangle(p, inner_pts[0], outer_pts[0], outer_pts[last]);
    endfunction

    task automatic apply_beat(input beat_t b, input row_answer_t answer);
        pt_t p;
        if (b.mode == MODE_LOAD) begin
            inner_pts[b.index].x = b.px;
            inner_pts[b.index].z = b.pz;
            outer_pts[b.index].x = b.ox;
            outer_pts[b.index].z = b.oz;
        end else begin
            p.x = b.px;
            p.z = b.pz;
            if (answer == BY_MODEL)
                pending_hits.insert(pending_hits.size(), strip_hit(p));
            else
                pending_hits.insert(pending_hits.size(), answer == SAYS_IN);
        end
    endtask

    task automatic send_beat(input beat_t b, input row_answer_t answer);
        int gap;
        gap = 0;
        while (int'($urandom_range(0, 99)) < snd_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= b.mode;
        s_point_index <= b.index;
        s_point_x     <= b.px;
        s_point_z     <= b.pz;
        s_outer_x     <= b.ox;
        s_outer_z     <= b.oz;
        do @(posedge aclk); while (!s_ready);
        apply_beat(b, answer);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_hits.size() != 0);
    endtask

    task automatic write_reg(input ptsp_pkg::cfg_reg_t sel, input logic [31:0] value);
        int          settle;
        logic [31:0] mask;
        settle = 2 * active_pairs() + 16;
        mask   = (sel == ptsp_pkg::CFG_POINT_COUNT) ? (32'd1 << ptsp_pkg::CNT_BITS) - 32'd1
                                                    : (32'd1 << ptsp_pkg::TOL_BITS) - 32'd1;
        hold_until_drained();
        repeat (settle) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == ptsp_pkg::CFG_POINT_COUNT) count_shadow = value[ptsp_pkg::CNT_BITS-1:0];
        else tol_shadow = value[ptsp_pkg::TOL_BITS-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== (value & mask))
            report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                      sel.name(), prdata, value & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic beat_t strip_pair(input int slot);
        beat_t b;
        int    xc;
        xc      = strip_x0 + slot * strip_step;
        b.mode  = MODE_LOAD;
        b.index = slot[ptsp_pkg::IDX_BITS-1:0];
        b.px    = crd(xc + int'($urandom_range(0, strip_step / 4)));
        b.pz    = crd(strip_zc + int'($urandom_range(0, strip_w / 4)));
        b.ox    = crd(xc + int'($urandom_range(0, strip_step / 4)));
        b.oz    = crd(strip_zc + strip_w + int'($urandom_range(0, strip_w / 4)));
        return b;
    endfunction

    task automatic build_strip();
        int n;
        n          = active_pairs();
        strip_x0   = -240000;
        strip_step = int'($urandom_range(64, 360000 / (n + 1)));
        strip_zc   = int'($urandom_range(0, 440000)) - 240000;
        strip_w    = int'($urandom_range(16, 200000));
        for (int s = 0; s < n; s++) send_beat(strip_pair(s), BY_MODEL);
    endtask

    function automatic beat_t next_beat();
        beat_t b;
        int    n;
        int    r;
        int    s;
        int    nx;
        n       = active_pairs();
        r       = int'($urandom_range(0, 99));
        s       = int'($urandom_range(0, n - 1));
        nx      = (s + 1) % n;
        b.mode  = MODE_QUERY;
        b.index = ptsp_pkg::IDX_BITS'($urandom);
        b.px    = CW'($urandom);
        b.pz    = CW'($urandom);
        b.ox    = CW'($urandom);
        b.oz    = CW'($urandom);
        if (r < 55) begin
            b.px = crd(strip_x0 - strip_step / 2
                       + int'($urandom_range(0, (n + 1) * strip_step)));
            b.pz = crd(strip_zc - strip_w / 4 + int'($urandom_range(0, strip_w * 3 / 2)));
        end else if (r < 70) begin
            case ($urandom_range(0, 2))
                0: begin
                    b.px = crd(int'(inner_pts[s].x));
                    b.pz = crd(int'(inner_pts[s].z));
                end
                1: begin
                    b.px = crd(int'(outer_pts[s].x));
                    b.pz = crd(int'(outer_pts[s].z));
                end
                default: begin
                    b.px = crd(int'((inner_pts[s].x + outer_pts[s].x + inner_pts[nx].x) / 3));
                    b.pz = crd(int'((inner_pts[s].z + outer_pts[s].z + inner_pts[nx].z) / 3));
                end
            endcase
        end else if (r < 82) begin
            b = strip_pair(s);
        end else if (r >= 91) begin
            b.mode = MODE_LOAD;
        end
        return b;
    endfunction

    function automatic row_t ld(input int idx, input int px, input int pz,
                                input int ox, input int oz);
        row_t r;
        r.kind    = ROW_LOAD;
        r.sel     = ptsp_pkg::CFG_POINT_COUNT;
        r.value   = '0;
        r.b.mode  = MODE_LOAD;
        r.b.index = idx[ptsp_pkg::IDX_BITS-1:0];
        r.b.px    = crd(px);
        r.b.pz    = crd(pz);
        r.b.ox    = crd(ox);
        r.b.oz    = crd(oz);
        r.answer  = BY_MODEL;
        return r;
    endfunction

    function automatic row_t qr(input int px, input int pz, input row_answer_t answer);
        row_t r;
        r        = ld(0, px, pz, 0, 0);
        r.kind   = ROW_QUERY;
        r.b.mode = MODE_QUERY;
        r.answer = answer;
        return r;
    endfunction

    function automatic row_t cf(input ptsp_pkg::cfg_reg_t sel, input logic [31:0] value);
        row_t r;
        r       = ld(0, 0, 0, 0, 0);
        r.kind  = ROW_CFG;
        r.sel   = sel;
        r.value = value;
        return r;
    endfunction

    task automatic plan_phase(input int p, output logic [31:0] cnt, output logic [31:0] tol,
                              output int items, output logic rebuild);
        rebuild = 1'b1;
        case (p)
            0:  begin cnt = 3;   tol = ptsp_pkg::TOLERANCE_RESET; items = 70; end
            1:  begin cnt = 8;   tol = 0;                         items = 70; end
            2:  begin cnt = 16;  tol = 32'h000F_FFFF;             items = 70; end
            3:  begin cnt = 256; tol = ptsp_pkg::TOLERANCE_RESET; items = 30; end
            4:  begin
                cnt = 32'hFFFF_FFFF; tol = 50000; items = 30; rebuild = 1'b0;
            end
            5:  begin cnt = 0;   tol = ptsp_pkg::TOLERANCE_RESET; items = 60; end
            6:  begin cnt = 5;   tol = $urandom_range(0, 1048575); items = 70; end
            7:  begin cnt = 32;  tol = ptsp_pkg::TOLERANCE_RESET; items = 70; end
            8:  begin cnt = 1;   tol = 200;                       items = 60; end
            9:  begin cnt = 12;  tol = $urandom_range(0, 1048575); items = 70; end
            10: begin cnt = 4;   tol = ptsp_pkg::TOLERANCE_RESET; items = 70; end
            default: begin cnt = 64; tol = 32'hFFFF_FFFF;         items = 50; end
        endcase
    endtask

    always @(posedge aclk) m_ready <= (int'($urandom_range(0, 99)) >= rcv_idle_pct);

    always @(posedge aclk) begin
        logic want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none outstanding",
                                          result_seq));
            end else begin
                want = pending_hits.pop_front();
                if (m_on_strip !== want)
                    report_mismatch($sformatf("result %0d: on_strip %b, expected %b",
                                              result_seq, m_on_strip, want));
            end
            result_seq++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do @(posedge aclk); while (quiet_cycles < QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        row_t         rows [$];
        logic [31:0]  cnt_val;
        logic [31:0]  tol_val;
        int           items;
        logic         rebuild;

        rows.insert(rows.size(), ld(0, 0, 0, 0, 25600));
        rows.insert(rows.size(), ld(1, 25600, 0, 25600, 25600));
        rows.insert(rows.size(), ld(2, 51200, 0, 51200, 25600));
        rows.insert(rows.size(), qr(6400, 6400, SAYS_IN));
        rows.insert(rows.size(), qr(-100000, -100000, SAYS_OUT));
        rows.insert(rows.size(), qr(25600, 0, SAYS_IN));
        rows.insert(rows.size(), qr(524287, 524287, SAYS_OUT));
        rows.insert(rows.size(), qr(-524288, -524288, SAYS_OUT));
        rows.insert(rows.size(), qr(38400, 12800, BY_MODEL));
        rows.insert(rows.size(), ld(255, -524288, 524287, 524287, -524288));
        rows.insert(rows.size(), ld(3, -524288, -524288, 524287, 524287));
        rows.insert(rows.size(), cf(ptsp_pkg::CFG_POINT_COUNT, 4));
        rows.insert(rows.size(), qr(0, 100, BY_MODEL));
        rows.insert(rows.size(), qr(524287, 524287, SAYS_IN));
        rows.insert(rows.size(), qr(-524288, 524287, BY_MODEL));
        rows.insert(rows.size(), cf(ptsp_pkg::CFG_TOLERANCE, 0));
        rows.insert(rows.size(), qr(6400, 6400, SAYS_IN));
        rows.insert(rows.size(), qr(6400, -1, BY_MODEL));
        rows.insert(rows.size(), cf(ptsp_pkg::CFG_TOLERANCE, 32'h000F_FFFF));
        rows.insert(rows.size(), qr(-1, 12800, BY_MODEL));
        rows.insert(rows.size(), cf(ptsp_pkg::CFG_POINT_COUNT, 0));
        rows.insert(rows.size(), qr(0, 12800, SAYS_IN));
        rows.insert(rows.size(), qr(25600, 0, SAYS_OUT));
        rows.insert(rows.size(), cf(ptsp_pkg::CFG_POINT_COUNT, 3));
        rows.insert(rows.size(), cf(ptsp_pkg::CFG_TOLERANCE, ptsp_pkg::TOLERANCE_RESET));
        rows.insert(rows.size(), qr(30000, 20000, BY_MODEL));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_reg(rows[i].sel, rows[i].value);
            else send_beat(rows[i].b, rows[i].answer);
        end

        for (int p = 0; p < 12; p++) begin
            plan_phase(p, cnt_val, tol_val, items, rebuild);
            snd_idle_pct = (p < 4) ? 30 : (p < 8) ? 83 : 0;
            rcv_idle_pct = (p < 4) ? 83 : (p < 8) ? 30 : 0;
            write_reg(ptsp_pkg::CFG_POINT_COUNT, cnt_val);
            write_reg(ptsp_pkg::CFG_TOLERANCE, tol_val);
            if (rebuild) build_strip();
            for (int k = 0; k < items; k++) begin
                if (int'($urandom_range(0, 99)) < 3) hold_until_drained();
                send_beat(next_beat(), BY_MODEL);
            end
        end

        hold_until_drained();
        repeat (2 * active_pairs() + 16) @(posedge aclk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
